// File: design/rcbi_pkg.sv
// Package for the ray / convex box intersection block.
// Holds shared constants, controller state type and the command/status structs.
package rcbi_pkg;

    localparam int NumFaces  = 6;
    localparam int CoordBits = 16;
    localparam int FracBits  = 12;
    localparam int IdxBits   = 3;
    localparam int DivBits   = 64;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_RAY  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DOT,
        S_LAUNCH,
        S_DIV,
        S_SIDE,
        S_NEXT,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic init;       // latch ray, clear best
        logic dot;        // form num/den for current face
        logic div_start;  // launch the dividers
        logic side;       // side test, one face j per cycle
        logic side_clr;   // reset side check for a new face
        logic keep;       // update best if this face passed
        logic [IdxBits-1:0] face;
        logic [IdxBits-1:0] face_j;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic den_zero;
        logic div_done;
    } t_status;

endpackage

// File: design/rcbi_div.sv
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rcbi_pkg for the operand width.
module rcbi_div #(
    parameter int W = rcbi_pkg::DivBits
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    output logic                o_done,
    output logic signed [W-1:0] o_quo
);
    localparam int CntBits = $clog2(W + 1);

    logic [W-1:0]       r_rem, n_rem;
    logic [W-1:0]       r_q, n_q;
    logic [W-1:0]       r_d;
    logic               r_neg;
    logic [CntBits-1:0] r_cnt;
    logic               r_busy;
    logic [W:0]         w_trial;
    logic [W-1:0]       w_shift;

    always_comb begin
        w_shift = {r_rem[W-2:0], r_q[W-1]};
        w_trial = {1'b0, w_shift} - {1'b0, r_d};
        n_q     = {r_q[W-2:0], ~w_trial[W]};
        n_rem   = w_trial[W] ? w_shift : w_trial[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CntBits'(W);
            r_rem  <= '0;
            r_q    <= i_num[W-1] ? W'(-i_num) : i_num;
            r_d    <= i_den[W-1] ? W'(-i_den) : i_den;
            r_neg  <= i_num[W-1] ^ i_den[W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CntBits'(1)) r_busy <= 1'b0;
        end
    end

    assign o_done = r_busy && (r_cnt == CntBits'(1));
    assign o_quo  = r_neg ? W'(-n_q) : n_q;
endmodule

// File: design/rcbi_ctrl.sv
// Controller of the ray / box block: sequences faces, divide and side tests.
// Depends on rcbi_pkg for the state type and command/status structs.
module rcbi_ctrl #(
    parameter int NUM_FACES = rcbi_pkg::NumFaces
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  rcbi_pkg::t_status i_stat,
    output rcbi_pkg::t_cmd   o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    localparam int IB = rcbi_pkg::IdxBits;

    rcbi_pkg::t_state r_state, n_state;
    logic [IB-1:0] r_face, r_j;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcbi_pkg::S_IDLE: if (i_go) n_state = rcbi_pkg::S_DOT;
            rcbi_pkg::S_DOT:  n_state = rcbi_pkg::S_LAUNCH;
            rcbi_pkg::S_LAUNCH:
                n_state = i_stat.den_zero ? rcbi_pkg::S_NEXT : rcbi_pkg::S_DIV;
            rcbi_pkg::S_DIV:
                if (i_stat.div_done) n_state = rcbi_pkg::S_SIDE;
            rcbi_pkg::S_SIDE:
                if (r_j == IB'(NUM_FACES - 1)) n_state = rcbi_pkg::S_NEXT;
            rcbi_pkg::S_NEXT:
                n_state = (r_face == IB'(NUM_FACES - 1)) ? rcbi_pkg::S_DONE
                                                        : rcbi_pkg::S_DOT;
            rcbi_pkg::S_DONE: n_state = rcbi_pkg::S_IDLE;
            default: n_state = rcbi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcbi_pkg::S_IDLE;
            r_face  <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == rcbi_pkg::S_IDLE) r_face <= '0;
            else if (r_state == rcbi_pkg::S_NEXT) r_face <= r_face + 1'b1;
            if (r_state == rcbi_pkg::S_SIDE) r_j <= r_j + 1'b1;
            else r_j <= '0;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.face      = r_face;
        o_cmd.face_j    = r_j;
        o_cmd.init      = (r_state == rcbi_pkg::S_IDLE) && i_go;
        o_cmd.dot       = (r_state == rcbi_pkg::S_DOT);
        // parallel faces never start the dividers
        o_cmd.div_start = (r_state == rcbi_pkg::S_LAUNCH) && !i_stat.den_zero;
        o_cmd.side_clr  = (r_state == rcbi_pkg::S_DOT);
        o_cmd.side      = (r_state == rcbi_pkg::S_SIDE);
        o_cmd.keep      = (r_state == rcbi_pkg::S_NEXT);
        o_busy          = (r_state != rcbi_pkg::S_IDLE);
        o_done          = (r_state == rcbi_pkg::S_DONE);
    end
endmodule

// File: design/rcbi_dp.sv
// Datapath of the ray / box block: face tables, dot products, dividers,
// side test and nearest-face selection. Depends on rcbi_pkg and rcbi_div.
module rcbi_dp #(
    parameter int NUM_FACES  = rcbi_pkg::NumFaces,
    parameter int COORD_BITS = rcbi_pkg::CoordBits
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [rcbi_pkg::IdxBits-1:0] i_idx,
    input  logic signed [COORD_BITS-1:0] i_ax, i_ay, i_az,
    input  logic signed [COORD_BITS-1:0] i_bx, i_by, i_bz,
    input  logic signed [COORD_BITS-1:0] i_off,
    input  rcbi_pkg::t_cmd               i_cmd,
    output rcbi_pkg::t_status            o_stat,
    output logic                         o_hit,
    output logic [rcbi_pkg::IdxBits-1:0] o_face,
    output logic signed [COORD_BITS-1:0] o_px, o_py, o_pz,
    output logic signed [COORD_BITS-1:0] o_nx, o_ny, o_nz
);
    localparam int W  = rcbi_pkg::DivBits;
    localparam int FB = rcbi_pkg::FracBits;
    localparam int IB = rcbi_pkg::IdxBits;
    localparam logic signed [W-1:0] Hi  = W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [W-1:0] Lo  = -Hi - 1;
    localparam logic signed [W-1:0] Lim = W'(64'sd1 <<< COORD_BITS);

    logic signed [COORD_BITS-1:0] r_nx [NUM_FACES];
    logic signed [COORD_BITS-1:0] r_ny [NUM_FACES];
    logic signed [COORD_BITS-1:0] r_nz [NUM_FACES];
    logic signed [COORD_BITS-1:0] r_d  [NUM_FACES];
    logic signed [COORD_BITS-1:0] r_cx [NUM_FACES];
    logic signed [COORD_BITS-1:0] r_cy [NUM_FACES];
    logic signed [COORD_BITS-1:0] r_cz [NUM_FACES];

    always_ff @(posedge i_clk) begin
        if (i_load && (i_idx < IB'(NUM_FACES))) begin
            r_nx[i_idx] <= i_ax; r_ny[i_idx] <= i_ay; r_nz[i_idx] <= i_az;
            r_cx[i_idx] <= i_bx; r_cy[i_idx] <= i_by; r_cz[i_idx] <= i_bz;
            r_d[i_idx]  <= i_off;
        end
    end

    logic signed [COORD_BITS-1:0] r_ox, r_oy, r_oz, r_vx, r_vy, r_vz;
    logic signed [W-1:0] r_num, r_den;
    logic signed [W-1:0] w_num, w_den;
    logic [IB-1:0] fi, fj;
    assign fi = i_cmd.face;
    assign fj = i_cmd.face_j;

    always_comb begin
        w_den = W'(r_nx[fi] * r_vx) + W'(r_ny[fi] * r_vy) + W'(r_nz[fi] * r_vz);
        w_num = (W'(r_d[fi]) <<< FB)
              - (W'(r_nx[fi] * r_ox) + W'(r_ny[fi] * r_oy) + W'(r_nz[fi] * r_oz));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_ox <= i_ax; r_oy <= i_ay; r_oz <= i_az;
            r_vx <= i_bx; r_vy <= i_by; r_vz <= i_bz;
        end
        if (i_cmd.dot) begin
            r_num <= w_num;
            r_den <= w_den;
        end
    end

    assign o_stat.den_zero = (r_den == '0);

    // num products are formed from the registered num, one per x/y/z divider;
    // num only needs enough bits for d*2^12 - n.o
    localparam int NumW0 = ((COORD_BITS + FB > 2 * COORD_BITS + 2) ? COORD_BITS + FB
                                                                    : 2 * COORD_BITS + 2) + 1;
    localparam int NB    = (NumW0 > W) ? W : NumW0;
    localparam int PB    = NB + COORD_BITS;

    logic signed [NB-1:0] w_nn;
    logic signed [PB-1:0] w_pv_x, w_pv_y, w_pv_z;
    logic signed [W-1:0] w_dn_t, w_dn_x, w_dn_y, w_dn_z;
    assign w_nn   = r_num[NB-1:0];
    assign w_pv_x = w_nn * r_vx;
    assign w_pv_y = w_nn * r_vy;
    assign w_pv_z = w_nn * r_vz;
    assign w_dn_t = r_num <<< FB;
    assign w_dn_x = W'(w_pv_x);
    assign w_dn_y = W'(w_pv_y);
    assign w_dn_z = W'(w_pv_z);

    logic d_t, d_x, d_y, d_z;
    logic signed [W-1:0] q_t, q_x, q_y, q_z;
    rcbi_div #(.W(W)) u_div_t (.i_clk, .i_rst_n, .i_start(i_cmd.div_start),
        .i_num(w_dn_t), .i_den(r_den), .o_done(d_t), .o_quo(q_t));
    rcbi_div #(.W(W)) u_div_x (.i_clk, .i_rst_n, .i_start(i_cmd.div_start),
        .i_num(w_dn_x), .i_den(r_den), .o_done(d_x), .o_quo(q_x));
    rcbi_div #(.W(W)) u_div_y (.i_clk, .i_rst_n, .i_start(i_cmd.div_start),
        .i_num(w_dn_y), .i_den(r_den), .o_done(d_y), .o_quo(q_y));
    rcbi_div #(.W(W)) u_div_z (.i_clk, .i_rst_n, .i_start(i_cmd.div_start),
        .i_num(w_dn_z), .i_den(r_den), .o_done(d_z), .o_quo(q_z));
    assign o_stat.div_done = d_t & d_x & d_y & d_z;

    function automatic logic signed [COORD_BITS-1:0] sat_add(
        input logic signed [W-1:0] q, input logic signed [COORD_BITS-1:0] b);
        logic signed [W-1:0] qc, r;
        qc = (q > Lim) ? Lim : ((q < -Lim) ? -Lim : q);
        r  = qc + W'(b);
        r  = (r > Hi) ? Hi : ((r < Lo) ? Lo : r);
        return r[COORD_BITS-1:0];
    endfunction

    logic [W-1:0] r_t;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;
    always_ff @(posedge i_clk) begin
        if (o_stat.div_done) begin
            r_t  <= q_t[W-1] ? W'(-q_t) : q_t;
            r_px <= sat_add(q_x, r_ox);
            r_py <= sat_add(q_y, r_oy);
            r_pz <= sat_add(q_z, r_oz);
        end
    end

    // side test against face j
    logic signed [W-1:0] w_dj, w_sa, w_sb;
    logic w_ok;
    always_comb begin
        w_dj = W'(r_d[fj]) <<< FB;
        w_sa = W'(r_nx[fj] * r_px) + W'(r_ny[fj] * r_py) + W'(r_nz[fj] * r_pz) - w_dj;
        w_sb = W'(r_nx[fj] * r_cx[fi]) + W'(r_ny[fj] * r_cy[fi])
             + W'(r_nz[fj] * r_cz[fi]) - w_dj;
        w_ok = (fj == fi) || ((w_sa != '0) && (w_sb != '0) && (w_sa[W-1] == w_sb[W-1]));
    end

    logic r_pass, r_valid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass  <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_cmd.side_clr) begin
            r_pass  <= 1'b1;
            r_valid <= 1'b0;
        end else if (i_cmd.side) begin
            r_valid <= 1'b1;
            if (!w_ok) r_pass <= 1'b0;
        end
    end

    logic         r_hit;
    logic [IB-1:0] r_bi;
    logic [W-1:0] r_bt;
    logic signed [COORD_BITS-1:0] r_bpx, r_bpy, r_bpz, r_bnx, r_bny, r_bnz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.init) begin
            r_hit <= 1'b0;
            r_bi  <= IB'(NUM_FACES);
            r_bpx <= '0; r_bpy <= '0; r_bpz <= '0;
            r_bnx <= '0; r_bny <= '0;
            r_bnz <= COORD_BITS'(1 << FB);
            r_bt  <= '0;
        end else if (i_cmd.keep && r_valid && r_pass && (!r_hit || r_t < r_bt)) begin
            r_hit <= 1'b1;
            r_bi  <= fi;
            r_bt  <= r_t;
            r_bpx <= r_px; r_bpy <= r_py; r_bpz <= r_pz;
            r_bnx <= r_nx[fi]; r_bny <= r_ny[fi]; r_bnz <= r_nz[fi];
        end
    end

    assign o_hit  = r_hit;
    assign o_face = r_bi;
    assign o_px = r_bpx; assign o_py = r_bpy; assign o_pz = r_bpz;
    assign o_nx = r_bnx; assign o_ny = r_bny; assign o_nz = r_bnz;
endmodule

// File: design/ray_convex_box_intersect.sv
// Top level of the ray / convex box intersection block.
// Depends on rcbi_pkg, rcbi_ctrl, rcbi_dp (and rcbi_div below it).
//
// Usage:
//   Raise start with the payload while busy is low; that beat is taken.
//   i_req_type = 0 writes face slot i_face_index (normal, centre, offset)
//   in the same cycle; no result follows and busy stays low.
//   i_req_type = 1 casts a ray (origin on vec_a, direction on vec_b).
//   Each face goes through: dot products, a launch step that skips faces
//   parallel to the ray, four 64-bit restoring dividers in parallel
//   (bit-serial), side tests of the hit point against every face in turn
//   and a select step; a parallel face goes from launch straight to select.
//   Busy stays high until the result is shown, and no new beat is taken
//   while it is high; the next beat can be taken as soon as busy is low.
//   The result is shown for one cycle with o_valid, in the last busy cycle;
//   the receiver cannot stall it.
//   Reset (synchronous, active low) returns the controller to idle; the
//   face tables are not cleared and must be loaded before the first ray.
module ray_convex_box_intersect #(
    parameter int NUM_FACES  = rcbi_pkg::NumFaces,
    parameter int COORD_BITS = rcbi_pkg::CoordBits
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_req_type,
    input  logic [rcbi_pkg::IdxBits-1:0] i_face_index,
    input  logic signed [COORD_BITS-1:0] i_vec_a_x, i_vec_a_y, i_vec_a_z,
    input  logic signed [COORD_BITS-1:0] i_vec_b_x, i_vec_b_y, i_vec_b_z,
    input  logic signed [COORD_BITS-1:0] i_plane_offset,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic [rcbi_pkg::IdxBits-1:0] o_hit_face,
    output logic signed [COORD_BITS-1:0] o_point_x, o_point_y, o_point_z,
    output logic signed [COORD_BITS-1:0] o_normal_x, o_normal_y, o_normal_z
);
    rcbi_pkg::t_cmd    w_cmd;
    rcbi_pkg::t_status w_stat;
    logic w_acc;

    assign w_acc = start && !busy;

    rcbi_ctrl #(.NUM_FACES(NUM_FACES)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_go(w_acc && (i_req_type == rcbi_pkg::REQ_RAY)),
        .i_stat(w_stat), .o_cmd(w_cmd), .o_busy(busy), .o_done(o_valid));

    rcbi_dp #(.NUM_FACES(NUM_FACES), .COORD_BITS(COORD_BITS)) u_dp (
        .i_clk, .i_rst_n,
        .i_load(w_acc && (i_req_type == rcbi_pkg::REQ_LOAD)),
        .i_idx(i_face_index),
        .i_ax(i_vec_a_x), .i_ay(i_vec_a_y), .i_az(i_vec_a_z),
        .i_bx(i_vec_b_x), .i_by(i_vec_b_y), .i_bz(i_vec_b_z),
        .i_off(i_plane_offset),
        .i_cmd(w_cmd), .o_stat(w_stat),
        .o_hit(o_hit), .o_face(o_hit_face),
        .o_px(o_point_x), .o_py(o_point_y), .o_pz(o_point_z),
        .o_nx(o_normal_x), .o_ny(o_normal_y), .o_nz(o_normal_z));
endmodule
